FILE: rtl/rdp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rdp_pkg: shared types, constants and helpers of the date parser
// Request payloads, the parse state record, name tables and the per-character
// scanner step used by the top level.
// ----------------------------------------------------------------------------
package rdp_pkg;

  // input request: one character or a terminator
  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
  } in_t;

  // result request: parsed date or invalid
  typedef struct packed {
    logic        valid_res;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
  } out_t;

  // parse phases, one-hot
  typedef enum logic [10:0] {
    PH_LEAD     = 11'b000_0000_0001,
    PH_PREFIX   = 11'b000_0000_0010,
    PH_AFTER1   = 11'b000_0000_0100,
    PH_AFTER2   = 11'b000_0000_1000,
    PH_DAY_WS   = 11'b000_0001_0000,
    PH_DAY_DIG  = 11'b000_0010_0000,
    PH_MON_WS   = 11'b000_0100_0000,
    PH_MON_TOK  = 11'b000_1000_0000,
    PH_YEAR_WS  = 11'b001_0000_0000,
    PH_YEAR_DIG = 11'b010_0000_0000,
    PH_DONE     = 11'b100_0000_0000
  } phase_e;

  // parse state carried between characters
  typedef struct packed {
    phase_e      phase;
    logic [15:0] prefix_chars;
    logic [1:0]  prefix_count;
    logic [7:0]  day_value;
    logic        number_negative;
    logic        have_digit;
    logic [23:0] month_chars;
    logic [1:0]  month_char_count;
    logic [31:0] year_value;
    logic        failed;
  } state_t;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_COMMA = 8'd44;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  localparam logic [31:0] YEAR_MAG_LIMIT = 32'h8000_0000;
  localparam logic [31:0] YEAR_POS_MAX   = 32'h7FFF_FFFF;
  localparam logic [6:0]  PIVOT_RESET    = 7'd50;
  localparam int          YEAR_BASE_OLD  = 1900;
  localparam int          YEAR_BASE_NEW  = 2000;
  localparam int          NUM_DAYS       = 7;
  localparam int          NUM_MONTHS     = 12;
  localparam logic [3:0]  FEB_IDX        = 4'd1;
  localparam logic [1:0]  TOKEN_LEN      = 2'd3;
  localparam logic [1:0]  PREFIX_PAIR    = 2'd2;
  localparam logic [4:0]  FEB_LEAP_DAYS  = 5'd29;

  // three-letter names, packed first character high
  localparam logic [23:0] DAY_NAMES [NUM_DAYS] = '{
    24'h53756E, 24'h4D6F6E, 24'h547565, 24'h576564,
    24'h546875, 24'h467269, 24'h536174
  };
  localparam logic [23:0] MONTH_NAMES [NUM_MONTHS] = '{
    24'h4A616E, 24'h466562, 24'h4D6172, 24'h417072, 24'h4D6179, 24'h4A756E,
    24'h4A756C, 24'h417567, 24'h536570, 24'h4F6374, 24'h4E6F76, 24'h446563
  };
  localparam logic [4:0] MONTH_DAYS [NUM_MONTHS] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // state after reset and after each terminator
  function automatic state_t clear_state();
    state_t s;
    s = '0;
    s.phase = PH_LEAD;
    return s;
  endfunction

  function automatic logic is_ws(logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_day_name(logic [23:0] k);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_DAYS; i++) begin
      if (DAY_NAMES[i] == k) hit = 1'b1;
    end
    return hit;
  endfunction

  // one scanner step; front_only drops the year digit datapath, which the
  // day-name replay never reaches
  function automatic state_t scan_char(state_t st, logic [7:0] c, logic front_only);
    state_t      s;
    logic        stop;
    logic [35:0] m;
    logic [7:0]  dig;
    s    = st;
    stop = 1'b0;
    m    = '0;
    dig  = c - CH_ZERO;
    // failed text and early zero byte
    if (s.failed) begin
      stop = 1'b1;
    end else if (c == CH_NUL) begin
      if ((s.phase == PH_YEAR_DIG && s.have_digit) || s.phase == PH_DONE) s.phase = PH_DONE;
      else s.failed = 1'b1;
      stop = 1'b1;
    end
    // after day name: white space, optional comma
    if (!stop && s.phase == PH_AFTER1) begin
      if (is_ws(c)) stop = 1'b1;
      else if (c == CH_COMMA) begin
        s.phase = PH_AFTER2;
        stop    = 1'b1;
      end else s.phase = PH_DAY_WS;
    end
    if (!stop && s.phase == PH_AFTER2) begin
      if (is_ws(c)) stop = 1'b1;
      else s.phase = PH_DAY_WS;
    end
    // start of day number
    if (!stop && s.phase == PH_DAY_WS) begin
      stop = 1'b1;
      if (!is_ws(c)) begin
        if (c == CH_PLUS || c == CH_MINUS) begin
          s.number_negative = (c == CH_MINUS);
          s.have_digit      = 1'b0;
          s.day_value       = '0;
          s.phase           = PH_DAY_DIG;
        end else if (is_digit(c)) begin
          s.number_negative = 1'b0;
          s.have_digit      = 1'b1;
          s.day_value       = dig;
          s.phase           = PH_DAY_DIG;
        end else begin
          s.failed = 1'b1;
        end
      end
    end
    // day digits, modulo 256
    if (!stop && s.phase == PH_DAY_DIG) begin
      if (is_digit(c)) begin
        s.day_value  = (s.day_value << 3) + (s.day_value << 1) + dig;
        s.have_digit = 1'b1;
        stop         = 1'b1;
      end else if (!s.have_digit) begin
        s.failed = 1'b1;
        stop     = 1'b1;
      end else begin
        if (s.number_negative) s.day_value = 8'd0 - s.day_value;
        s.phase = PH_MON_WS;
      end
    end
    // month token
    if (!stop && s.phase == PH_MON_WS) begin
      stop = 1'b1;
      if (!is_ws(c)) begin
        s.month_chars      = {16'd0, c};
        s.month_char_count = 2'd1;
        s.phase            = PH_MON_TOK;
      end
    end
    if (!stop && s.phase == PH_MON_TOK) begin
      stop = 1'b1;
      if (!is_ws(c)) begin
        if (s.month_char_count < TOKEN_LEN) begin
          s.month_chars      = {s.month_chars[15:0], c};
          s.month_char_count = s.month_char_count + 2'd1;
        end
      end else begin
        s.phase = PH_YEAR_WS;
      end
    end
    // start of year number
    if (!stop && s.phase == PH_YEAR_WS) begin
      stop = 1'b1;
      if (!is_ws(c)) begin
        if (c == CH_PLUS || c == CH_MINUS) begin
          s.number_negative = (c == CH_MINUS);
          s.have_digit      = 1'b0;
          s.year_value      = '0;
          s.phase           = PH_YEAR_DIG;
        end else if (is_digit(c)) begin
          s.number_negative = 1'b0;
          s.have_digit      = 1'b1;
          s.year_value      = {24'd0, dig};
          s.phase           = PH_YEAR_DIG;
        end else begin
          s.failed = 1'b1;
        end
      end
    end
    // year digits, magnitude saturating
    if (!stop && !front_only && s.phase == PH_YEAR_DIG) begin
      if (is_digit(c)) begin
        m = ({4'd0, s.year_value} << 3) + ({4'd0, s.year_value} << 1) + {28'd0, dig};
        s.year_value = (m > {4'd0, YEAR_MAG_LIMIT}) ? YEAR_MAG_LIMIT : m[31:0];
        s.have_digit = 1'b1;
      end else if (!s.have_digit) begin
        s.failed = 1'b1;
      end else begin
        s.phase = PH_DONE;
      end
    end
    return s;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/rdp_date_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rdp_date_check: end-of-text date evaluation
// Matches the month token, windows and truncates the year, applies the
// Gregorian leap rule and range checks the day.
// ----------------------------------------------------------------------------
module rdp_date_check (
  input  var rdp_pkg::state_t st_i,
  input  wire logic [6:0]     pivot_i,
  output var rdp_pkg::out_t   res_o
);

  logic               month_hit;
  logic [3:0]         month_idx;
  logic signed [32:0] year_s;
  logic signed [32:0] year_w;
  logic [15:0]        y16;
  logic [32:0]        prod;
  logic [11:0]        q25;
  logic [15:0]        q25_back;
  logic               div4, div16, div25, leap;
  logic [4:0]         dim;
  logic               phase_ok;
  logic               ok;

  // month lookup over the name table
  always_comb begin
    month_hit = 1'b0;
    month_idx = '0;
    for (int i = 0; i < rdp_pkg::NUM_MONTHS; i++) begin
      if (!month_hit && rdp_pkg::MONTH_NAMES[i] == st_i.month_chars) begin
        month_hit = 1'b1;
        month_idx = 4'(i);
      end
    end
  end

  // signed year with saturation, then century window
  always_comb begin
    if (st_i.number_negative) year_s = 33'sd0 - $signed({1'b0, st_i.year_value});
    else if (st_i.year_value > rdp_pkg::YEAR_POS_MAX)
      year_s = $signed({1'b0, rdp_pkg::YEAR_POS_MAX});
    else year_s = $signed({1'b0, st_i.year_value});
    if (year_s < 33'(rdp_pkg::YEAR_BASE_OLD)) begin
      if (year_s < $signed({26'd0, pivot_i})) year_w = year_s + 33'(rdp_pkg::YEAR_BASE_NEW);
      else year_w = year_s + 33'(rdp_pkg::YEAR_BASE_OLD);
    end else begin
      year_w = year_s;
    end
  end

  assign y16 = year_w[15:0];

  // divisibility by 25 via reciprocal 2^21/25, exact for 16-bit values
  assign prod     = {17'd0, y16} * 33'd83887;
  assign q25      = prod[32:21];
  assign q25_back = {q25, 4'd0} + {1'b0, q25, 3'd0} + {4'd0, q25};
  assign div25    = (q25_back == y16);
  assign div4     = (y16[1:0] == 2'd0);
  assign div16    = (y16[3:0] == 4'd0);
  // leap: by 4 and not 100, or by 400
  assign leap     = (div4 && !div25) || (div16 && div25);

  always_comb begin
    dim = rdp_pkg::MONTH_DAYS[month_idx];
    if (month_idx == rdp_pkg::FEB_IDX && leap) dim = rdp_pkg::FEB_LEAP_DAYS;
  end

  assign phase_ok = (st_i.phase == rdp_pkg::PH_YEAR_DIG && st_i.have_digit) ||
                    (st_i.phase == rdp_pkg::PH_DONE);

  assign ok = !st_i.failed && phase_ok && (st_i.month_char_count == rdp_pkg::TOKEN_LEN) &&
              month_hit && (y16 != 16'd0) && (st_i.day_value != 8'd0) &&
              (st_i.day_value <= {3'd0, dim});

  // result fields, zero when invalid
  always_comb begin
    res_o = '0;
    if (ok) begin
      res_o.valid_res = 1'b1;
      res_o.day       = st_i.day_value[4:0];
      res_o.month     = month_idx + 4'd1;
      res_o.year      = y16;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/rfc822_date_parser_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfc822_date_parser_unit: streaming date text parser
// Takes one character per request and gives one date result per terminator.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------
//  cfg     | in        | cfg_we_i                  | cfg_wdata_i (century pivot)
//  in      | in        | in_valid_i / in_stall_o   | in_data_i  (ch, is_end)
//  out     | out       | out_valid_o / out_stall_i | out_data_o (valid_res, date)
//
//  one character per cycle sustained; a request is held in the input
//  register and the state update runs from there; a result shows in the next cycle
//  the state update of one character (day-name replay included) sets the cycle
//  reset clears parse state, pivot returns to 50, both registers empty
//  a terminator held in the input register while the output holds a result
//  stalls the input; characters move on regardless of output stall
// ----------------------------------------------------------------------------
module rfc822_date_parser_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [6:0]   cfg_wdata_i,
  input  wire logic         in_valid_i,
  output var  logic         in_stall_o,
  input  var  rdp_pkg::in_t in_data_i,
  output var  logic         out_valid_o,
  input  wire logic         out_stall_i,
  output var  rdp_pkg::out_t out_data_o
);

  logic [6:0]       pivot_val_q;
  logic             in_vld_q;
  rdp_pkg::in_t     in_q;
  rdp_pkg::state_t  st_q, st_d;
  rdp_pkg::state_t  rp1, rp2, rp3;
  logic             out_vld_q;
  rdp_pkg::out_t    out_q;
  rdp_pkg::out_t    res;
  logic             out_free;
  logic             advance;
  logic             in_accept;

  // handshake control
  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && (!in_q.is_end || out_free);
  assign in_stall_o = in_vld_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  // pivot register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pivot_val_q <= rdp_pkg::PIVOT_RESET;
    end else if (cfg_we_i) begin
      pivot_val_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_accept) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) in_q <= in_data_i;
  end

  // day-name replay of the three buffered characters
  always_comb begin
    rp1 = st_q;
    rp1.phase = rdp_pkg::PH_DAY_WS;
    rp1 = rdp_pkg::scan_char(rp1, st_q.prefix_chars[15:8], 1'b1);
    rp2 = rdp_pkg::scan_char(rp1, st_q.prefix_chars[7:0], 1'b1);
    rp3 = rdp_pkg::scan_char(rp2, in_q.ch, 1'b1);
  end

  // next parse state
  always_comb begin
    st_d = st_q;
    if (in_q.is_end) begin
      st_d = rdp_pkg::clear_state();
    end else if (st_q.phase == rdp_pkg::PH_LEAD) begin
      if (!rdp_pkg::is_ws(in_q.ch)) begin
        st_d.prefix_chars = {8'd0, in_q.ch};
        st_d.prefix_count = 2'd1;
        st_d.phase        = rdp_pkg::PH_PREFIX;
      end
    end else if (st_q.phase == rdp_pkg::PH_PREFIX) begin
      if (st_q.prefix_count < rdp_pkg::PREFIX_PAIR) begin
        st_d.prefix_chars = {st_q.prefix_chars[7:0], in_q.ch};
        st_d.prefix_count = rdp_pkg::PREFIX_PAIR;
      end else if (rdp_pkg::is_day_name({st_q.prefix_chars, in_q.ch})) begin
        st_d.phase = rdp_pkg::PH_AFTER1;
      end else begin
        st_d = rp3;
      end
    end else begin
      st_d = rdp_pkg::scan_char(st_q, in_q.ch, 1'b0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= rdp_pkg::clear_state();
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // date evaluation at the terminator
  rdp_date_check u_check (
    .st_i    (st_q),
    .pivot_i (pivot_val_q),
    .res_o   (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && in_q.is_end) begin
      out_vld_q <= 1'b1;
    end else if (out_vld_q && !out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_q.is_end) out_q <= res;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // invalid results carry zero fields
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.valid_res) |->
    (out_data_o.day == 5'd0 && out_data_o.month == 4'd0 && out_data_o.year == 16'd0))
    else $error("invalid result with nonzero fields");

  // valid results hold a real month and day
  a_valid_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.valid_res) |->
    (out_data_o.month >= 4'd1 && out_data_o.month <= 4'd12 && out_data_o.day != 5'd0))
    else $error("valid result out of range");

  // a processed terminator gives a result and clears the parse state
  a_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_q.is_end) |=> (out_vld_q && st_q.phase == rdp_pkg::PH_LEAD))
    else $error("terminator did not produce result or clear state");

  // only a terminator can stall the input
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_vld_q && in_q.is_end && out_vld_q && out_stall_i))
    else $error("input stalled without a blocked terminator");

  // pivot only moves on a write
  a_pivot_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_we_i |=> $stable(pivot_val_q))
    else $error("pivot changed without a write");

endmodule
`default_nettype wire
